@@ hdl/sdqd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Soft differential QPSK decode package
// Shared widths, sequencer states and the square root step.
// ----------------------------------------------------------------------------
package sdqd_pkg;

    localparam int SOFT_WIDTH = 8;
    localparam int PROD_W     = 2 * SOFT_WIDTH;
    localparam int ROOT_W     = SOFT_WIDTH;
    localparam int REM_W      = SOFT_WIDTH + 2;
    localparam int CNT_W      = (SOFT_WIDTH > 1) ? $clog2(SOFT_WIDTH) : 1;
    localparam int HIST_W     = 2 * SOFT_WIDTH;
    localparam int TDATA_W    = ((2 * SOFT_WIDTH + 7) / 8) * 8;

    localparam logic [ROOT_W-1:0] ROOT_MAX = {1'b0, {(ROOT_W-1){1'b1}}};
    localparam logic [CNT_W-1:0]  CNT_LAST = CNT_W'(SOFT_WIDTH - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_ABS,
        ST_ROOT,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
    } root_step_t;

    // One digit of the restoring square root: two radicand bits in, one root bit out.
    function automatic root_step_t root_step(input logic [REM_W-1:0] rem,
                                             input logic [ROOT_W-1:0] root,
                                             input logic [1:0] pair);
        logic [REM_W-1:0] rem_sh;
        logic [REM_W-1:0] trial;
        root_step_t       res;
        rem_sh = {rem[REM_W-3:0], pair};
        trial  = {root, 2'b01};
        if (rem_sh >= trial) begin
            res.rem  = rem_sh - trial;
            res.root = {root[ROOT_W-2:0], 1'b1};
        end else begin
            res.rem  = rem_sh;
            res.root = {root[ROOT_W-2:0], 1'b0};
        end
        return res;
    endfunction

endpackage

@@ hdl/sdqd_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module sdqd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1
) (
    input  logic                                       aclk,
    input  logic                                       wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                           wr_data,
    input  logic                                       rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                           rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ hdl/soft_differential_qpsk_decode_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Soft differential QPSK decode unit
// Signed square root of each soft symbol times the previous one, Q negated.
// ----------------------------------------------------------------------------
// The slave channel takes one beat per soft symbol pair, I in s_tdata[7:0]
// and Q in s_tdata[15:8]. The master channel returns one beat per input
// beat, decoded I in m_tdata[7:0] and decoded Q in m_tdata[15:8].
// The previous raw pair is held in a one-entry RAM. An accepted beat reads
// it, writes the new pair back, forms both products, takes magnitudes and
// runs an eight-step digit-by-digit square root on both branches together.
// A beat passes through the read, magnitude, root and output states in turn,
// and the unit accepts no new beat until the sequencer is back in idle.
// The result waits in an output register, so the next beat is accepted
// while the receiver stalls; the sequencer only holds when a second result
// is ready and the first has not yet been taken.
// Reset clears the sequencer, the output valid flag and the history valid
// flag, so the first beat after reset decodes against a zero history.
// ----------------------------------------------------------------------------
module soft_differential_qpsk_decode_unit
    import sdqd_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [TDATA_W-1:0] s_tdata,   // soft_i, soft_q
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [TDATA_W-1:0] m_tdata    // decoded_i, decoded_q
);

    state_t state_reg, state_next;

    logic [CNT_W-1:0]             cnt_reg, cnt_next;
    logic                         hist_valid_reg, hist_valid_next;
    logic                         m_valid_reg, m_valid_next;
    logic [TDATA_W-1:0]           m_data_reg, m_data_next;

    logic signed [SOFT_WIDTH-1:0] si_reg, sq_reg;
    logic signed [PROD_W-1:0]     pi_reg, pq_reg;
    logic                         neg_i_reg, neg_q_reg;
    logic [PROD_W-1:0]            rad_i_reg, rad_q_reg;
    logic [REM_W-1:0]             rem_i_reg, rem_q_reg;
    logic [ROOT_W-1:0]            root_i_reg, root_q_reg;

    logic                         accept;
    logic                         ram_rd_en;
    logic                         ram_wr_en;
    logic [HIST_W-1:0]            ram_rd_data;
    logic signed [SOFT_WIDTH-1:0] last_i, last_q;
    logic                         out_load;
    root_step_t                   step_i, step_q;
    logic [ROOT_W-1:0]            clamp_i, clamp_q;
    logic [SOFT_WIDTH-1:0]        dec_i, dec_q;

    sdqd_ram #(
        .WIDTH (HIST_W),
        .DEPTH (1)
    ) u_hist_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (1'b0),
        .wr_data ({sq_reg, si_reg}),
        .rd_en   (ram_rd_en),
        .rd_addr (1'b0),
        .rd_data (ram_rd_data)
    );

    assign accept = s_tvalid && s_tready;
    assign last_i = hist_valid_reg ? ram_rd_data[SOFT_WIDTH-1:0] : '0;
    assign last_q = hist_valid_reg ? ram_rd_data[HIST_W-1:SOFT_WIDTH] : '0;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_READ;
                end
            end
            ST_READ: state_next = ST_ABS;
            ST_ABS:  state_next = ST_ROOT;
            ST_ROOT: begin
                if (cnt_reg == CNT_LAST) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!m_valid_reg || m_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready  = 1'b0;
        ram_rd_en = 1'b0;
        ram_wr_en = 1'b0;
        out_load  = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready  = 1'b1;
                ram_rd_en = s_tvalid;
            end
            ST_READ: ram_wr_en = 1'b1;
            ST_ABS:  ;
            ST_ROOT: ;
            ST_OUT:  out_load = !m_valid_reg || m_tready;
            default: ;
        endcase
    end

    assign step_i = root_step(rem_i_reg, root_i_reg, rad_i_reg[PROD_W-1:PROD_W-2]);
    assign step_q = root_step(rem_q_reg, root_q_reg, rad_q_reg[PROD_W-1:PROD_W-2]);

    assign clamp_i = root_i_reg[ROOT_W-1] ? ROOT_MAX : root_i_reg;
    assign clamp_q = root_q_reg[ROOT_W-1] ? ROOT_MAX : root_q_reg;
    assign dec_i   = neg_i_reg ? SOFT_WIDTH'(-clamp_i) : clamp_i;
    assign dec_q   = neg_q_reg ? SOFT_WIDTH'(-clamp_q) : clamp_q;

    always_comb begin
        cnt_next        = cnt_reg;
        hist_valid_next = hist_valid_reg;
        m_valid_next    = m_valid_reg;
        m_data_next     = m_data_reg;
        if (state_reg == ST_READ) begin
            hist_valid_next = 1'b1;
        end
        if (state_reg == ST_ABS) begin
            cnt_next = '0;
        end else if (state_reg == ST_ROOT) begin
            cnt_next = cnt_reg + 1'b1;
        end
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end
        if (out_load) begin
            m_valid_next = 1'b1;
            m_data_next  = TDATA_W'({dec_q, dec_i});
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            cnt_reg        <= '0;
            hist_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            hist_valid_reg <= hist_valid_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
        if (accept) begin
            si_reg <= s_tdata[SOFT_WIDTH-1:0];
            sq_reg <= s_tdata[2*SOFT_WIDTH-1:SOFT_WIDTH];
        end
        if (state_reg == ST_READ) begin
            pi_reg <= PROD_W'(si_reg) * PROD_W'(last_i);
            pq_reg <= -(PROD_W'(sq_reg) * PROD_W'(last_q));
        end
        if (state_reg == ST_ABS) begin
            neg_i_reg  <= pi_reg[PROD_W-1];
            neg_q_reg  <= pq_reg[PROD_W-1];
            rad_i_reg  <= pi_reg[PROD_W-1] ? PROD_W'(-pi_reg) : PROD_W'(pi_reg);
            rad_q_reg  <= pq_reg[PROD_W-1] ? PROD_W'(-pq_reg) : PROD_W'(pq_reg);
            rem_i_reg  <= '0;
            rem_q_reg  <= '0;
            root_i_reg <= '0;
            root_q_reg <= '0;
        end else if (state_reg == ST_ROOT) begin
            rad_i_reg  <= {rad_i_reg[PROD_W-3:0], 2'b00};
            rad_q_reg  <= {rad_q_reg[PROD_W-3:0], 2'b00};
            rem_i_reg  <= step_i.rem;
            rem_q_reg  <= step_q.rem;
            root_i_reg <= step_i.root;
            root_q_reg <= step_q.root;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    a_accept_starts : assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> state_reg == ST_READ)
        else $error("accepted beat did not start the history read");

    a_busy_blocks : assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg != ST_IDLE |-> !s_tready)
        else $error("input accepted while a beat is in progress");

    a_root_length : assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_ROOT && cnt_reg == CNT_LAST |=> state_reg == ST_OUT)
        else $error("root iterations did not end after the last digit");

    a_no_min_code : assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[SOFT_WIDTH-1:0] != {1'b1, {(SOFT_WIDTH-1){1'b0}}} &&
                     m_tdata[2*SOFT_WIDTH-1:SOFT_WIDTH] != {1'b1, {(SOFT_WIDTH-1){1'b0}}})
        else $error("decoded root was not clamped");

    a_write_after_read : assert property (@(posedge aclk) disable iff (!aresetn)
        ram_wr_en |-> $past(ram_rd_en))
        else $error("history written back without a preceding read");

endmodule

@@ tb/sdqd_root_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Soft differential QPSK decode checker
// Watches both stream channels. Each input beat feeds a predictor that keeps
// its own copy of the previous soft pair and forms the signed floor roots.
// Each result beat is compared, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module sdqd_root_checker
    import sdqd_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    input  logic               s_tready,
    input  logic [TDATA_W-1:0] s_tdata,   // soft_i, soft_q
    input  logic               m_tvalid,
    input  logic               m_tready,
    input  logic [TDATA_W-1:0] m_tdata,   // decoded_i, decoded_q
    output int                 mismatch_count,
    output int                 pending_count
);

    logic signed [SOFT_WIDTH-1:0] prev_i;
    logic signed [SOFT_WIDTH-1:0] prev_q;
    logic [2*SOFT_WIDTH-1:0]      decoded_due [$];
    int                           errors = 0;

    function automatic logic [SOFT_WIDTH-1:0] signed_floor_root(input int product);
        int mag;
        int root;
        mag  = (product < 0) ? -product : product;
        root = 0;
        while ((root + 1) * (root + 1) <= mag) begin
            root++;
        end
        if (root > int'(ROOT_MAX)) begin
            root = int'(ROOT_MAX);
        end
        if (product < 0) begin
            root = -root;
        end
        return root[SOFT_WIDTH-1:0];
    endfunction

    always @(posedge aclk) begin
        logic signed [SOFT_WIDTH-1:0] cur_i;
        logic signed [SOFT_WIDTH-1:0] cur_q;
        logic [SOFT_WIDTH-1:0]        want_i;
        logic [SOFT_WIDTH-1:0]        want_q;
        logic [SOFT_WIDTH-1:0]        got_i;
        logic [SOFT_WIDTH-1:0]        got_q;
        logic [2*SOFT_WIDTH-1:0]      want;
        if (!aresetn) begin
            prev_i = '0;
            prev_q = '0;
            decoded_due.delete();
        end else begin
            if (s_tvalid && s_tready) begin
                cur_i  = s_tdata[SOFT_WIDTH-1:0];
                cur_q  = s_tdata[2*SOFT_WIDTH-1:SOFT_WIDTH];
                want_i = signed_floor_root(int'(cur_i) * int'(prev_i));
                want_q = signed_floor_root(-(int'(cur_q) * int'(prev_q)));
                decoded_due.push_back({want_q, want_i});
                prev_i = cur_i;
                prev_q = cur_q;
            end
            if (m_tvalid && m_tready) begin
                got_i = m_tdata[SOFT_WIDTH-1:0];
                got_q = m_tdata[2*SOFT_WIDTH-1:SOFT_WIDTH];
                if (decoded_due.size() == 0) begin
                    errors++;
                    if (errors <= 10) begin
                        $display("%t: result beat with no prediction waiting: I %0d Q %0d",
                                 $realtime, $signed(got_i), $signed(got_q));
                    end
                end else begin
                    want   = decoded_due.pop_front();
                    want_i = want[SOFT_WIDTH-1:0];
                    want_q = want[2*SOFT_WIDTH-1:SOFT_WIDTH];
                    if (got_i !== want_i || got_q !== want_q) begin
                        errors++;
                        if (errors <= 10) begin
                            $display("%t: decode mismatch: expected I %0d Q %0d, got I %0d Q %0d",
                                     $realtime, $signed(want_i), $signed(want_q),
                                     $signed(got_i), $signed(got_q));
                        end
                    end
                end
            end
        end
        mismatch_count <= errors;
        pending_count  <= decoded_due.size();
    end

endmodule

@@ tb/tb_soft_differential_qpsk_decode_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Soft differential QPSK decode unit testbench
// Drives directed corner pairs and then random soft pairs, mostly with random
// gaps, while the result side stalls at random and once for a long stretch. The
// checker beside the unit predicts and compares every result beat.
// ----------------------------------------------------------------------------
module tb_soft_differential_qpsk_decode_unit;
    import sdqd_pkg::*;

    localparam int BEATS_TOTAL = 1100;
    localparam int HOLD_CYCLES = 400;

    logic               aclk     = 1'b0;
    logic               aresetn  = 1'b0;
    logic               s_tvalid = 1'b0;
    logic [TDATA_W-1:0] s_tdata  = '0;
    logic               m_tready = 1'b0;
    logic               s_tready;
    logic               m_tvalid;
    logic [TDATA_W-1:0] m_tdata;
    int                 mismatch_count;
    int                 pending_count;

    always #10 aclk = ~aclk;

    soft_differential_qpsk_decode_unit u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    sdqd_root_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .mismatch_count (mismatch_count),
        .pending_count  (pending_count)
    );

    task automatic offer_pair(input logic [SOFT_WIDTH-1:0] soft_i,
                              input logic [SOFT_WIDTH-1:0] soft_q,
                              input bit gaps);
        while (gaps && $urandom_range(99) < 11) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= TDATA_W'({soft_q, soft_i});
        do begin
            @(posedge aclk);
        end while (!s_tready);
    endtask

    function automatic logic [SOFT_WIDTH-1:0] pick_soft();
        logic [SOFT_WIDTH-1:0] v;
        v = SOFT_WIDTH'($urandom);
        if ($urandom_range(9) < 2) begin
            case ($urandom_range(5))
                0: v = 8'h80;
                1: v = 8'h81;
                2: v = 8'hFF;
                3: v = 8'h00;
                4: v = 8'h01;
                default: v = 8'h7F;
            endcase
        end
        return v;
    endfunction

    initial begin : result_sink
        int  taken;
        int  hold_left;
        bit  held;
        taken     = 0;
        hold_left = 0;
        held      = 1'b0;
        forever begin
            @(posedge aclk);
            if (m_tvalid && m_tready) begin
                taken++;
            end
            if (!held && taken == 300) begin
                held      = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                m_tready <= 1'b0;
                hold_left--;
            end else if (taken >= 600 && taken < 800) begin
                m_tready <= 1'b1;
            end else begin
                m_tready <= ($urandom_range(99) >= 11);
            end
        end
    end

    initial begin : stimulus
        int n;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // Zero history first, then the clamped root in both signs.
        offer_pair(8'h00, 8'h00, 1'b0);
        offer_pair(8'h80, 8'h80, 1'b0);
        offer_pair(8'h80, 8'h80, 1'b0);
        offer_pair(8'h7F, 8'h7F, 1'b0);
        offer_pair(8'h7F, 8'h7F, 1'b0);
        offer_pair(8'hFF, 8'hFF, 1'b0);
        offer_pair(8'h01, 8'h01, 1'b0);
        offer_pair(8'h00, 8'h00, 1'b0);
        offer_pair(8'h80, 8'h7F, 1'b0);
        offer_pair(8'h80, 8'h7F, 1'b0);
        offer_pair(8'h7F, 8'h80, 1'b1);
        offer_pair(8'h81, 8'hFF, 1'b1);
        offer_pair(8'h02, 8'h03, 1'b1);
        offer_pair(8'h05, 8'hF9, 1'b1);
        offer_pair(8'hFD, 8'h04, 1'b1);
        offer_pair(8'h40, 8'hC0, 1'b1);
        offer_pair(8'h40, 8'hC0, 1'b1);
        offer_pair(8'hC0, 8'h40, 1'b1);
        offer_pair(8'h01, 8'h80, 1'b1);
        offer_pair(8'h80, 8'h01, 1'b1);
        offer_pair(8'h00, 8'h80, 1'b1);
        offer_pair(8'h55, 8'hAA, 1'b1);

        for (n = 22; n < BEATS_TOTAL; n++) begin
            offer_pair(pick_soft(), pick_soft(), !(n >= 650 && n < 850));
        end
        s_tvalid <= 1'b0;

        @(posedge aclk);
        while (pending_count != 0) begin
            @(posedge aclk);
        end
        repeat (40) @(posedge aclk);

        if (mismatch_count == 0 && pending_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin : watchdog
        #5_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
